### rtl/core/jhm_pkg.sv
// ============================================================================
// jhm_pkg: joint histogram with marginals, shared definitions
// Sizes, command codes, beat types and count helpers shared by the design and testbench.
// ============================================================================
package jhm_pkg;

    localparam int MAX_BINS_A   = 256;
    localparam int MAX_BINS_B   = 256;
    localparam int COUNT_BITS   = 32;

    localparam int A_IDX_W      = $clog2(MAX_BINS_A);
    localparam int B_IDX_W      = $clog2(MAX_BINS_B);
    localparam int JOINT_DEPTH  = MAX_BINS_A * MAX_BINS_B;
    localparam int JOINT_ADDR_W = $clog2(JOINT_DEPTH);
    localparam int CFG_W        = 9;

    localparam logic [1:0] KIND_ACC   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic CFG_BINS_A = 1'b0;
    localparam logic CFG_BINS_B = 1'b1;

    localparam logic [CFG_W-1:0] BINS_USED_RESET = 9'd256;

    typedef logic [COUNT_BITS-1:0]   count_t;
    typedef logic [A_IDX_W-1:0]      a_idx_t;
    typedef logic [B_IDX_W-1:0]      b_idx_t;
    typedef logic [JOINT_ADDR_W-1:0] joint_addr_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] code_a;
        logic [7:0] code_b;
    } item_t;

    typedef struct packed {
        logic [31:0] joint_count;
        logic [31:0] row_count;
        logic [31:0] col_count;
        logic        code_out_of_range;
    } result_t;

    typedef struct packed {
        logic        sweep;
        joint_addr_t sweep_addr;
        logic        clr_done;
    } ctrl_t;

    function automatic count_t sat_inc(input count_t v);
        count_t r;
        r = (v == '1) ? v : v + count_t'(1);
        return r;
    endfunction

    function automatic logic [31:0] out32(input count_t v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic logic code_ok(input logic [7:0] code, input logic [CFG_W-1:0] used,
                                     input int maxb);
        logic [15:0] lim;
        lim = (16'(used) < 16'(maxb)) ? 16'(used) : 16'(maxb);
        return 16'(code) < lim;
    endfunction

    function automatic joint_addr_t joint_addr(input a_idx_t a, input b_idx_t b);
        joint_addr_t r;
        r = JOINT_ADDR_W'(a) * JOINT_ADDR_W'(MAX_BINS_B) + JOINT_ADDR_W'(b);
        return r;
    endfunction

endpackage

### rtl/core/jhm_ram.sv
// ============================================================================
// jhm_ram: simple dual-port count memory
// One write port and one read port with registered read data.
// ============================================================================
module jhm_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we && (32'(waddr) < 32'(DEPTH)))
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/jhm_seq.sv
// ============================================================================
// jhm_seq: clearing sequencer
// Walks every bin address after reset and on a clear beat, holding busy high.
// ============================================================================
module jhm_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           clr_start,
    output logic           busy,
    output jhm_pkg::ctrl_t ctrl
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SWEEP = 1'b1;

    logic                 state_reg, state_next;
    logic                 report_reg, report_next;
    jhm_pkg::joint_addr_t addr_reg, addr_next;
    logic                 last;

    assign last = (addr_reg == jhm_pkg::JOINT_ADDR_W'(jhm_pkg::JOINT_DEPTH - 1));

    always_comb
    begin
        state_next  = state_reg;
        report_next = report_reg;
        addr_next   = addr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (clr_start)
                begin
                    state_next  = ST_SWEEP;
                    report_next = 1'b1;
                    addr_next   = '0;
                end
            end
            ST_SWEEP:
            begin
                addr_next = addr_reg + jhm_pkg::joint_addr_t'(1);
                if (last)
                begin
                    state_next  = ST_IDLE;
                    report_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SWEEP;
            report_reg <= 1'b0;
            addr_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            report_reg <= report_next;
            addr_reg   <= addr_next;
        end
    end

    assign busy            = (state_reg == ST_SWEEP);
    assign ctrl.sweep      = (state_reg == ST_SWEEP);
    assign ctrl.sweep_addr = addr_reg;
    assign ctrl.clr_done   = (state_reg == ST_SWEEP) && last && report_reg;

endmodule

### rtl/core/jhm_upd.sv
// ============================================================================
// jhm_upd: read-modify-write datapath
// Issues reads, forwards the previous write, saturates counts, writes back
// and registers the result beat.
// ============================================================================
module jhm_upd (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  jhm_pkg::item_t                cmd,
    input  logic [jhm_pkg::CFG_W-1:0]     bins_a_used,
    input  logic [jhm_pkg::CFG_W-1:0]     bins_b_used,
    input  jhm_pkg::ctrl_t                ctrl,
    input  jhm_pkg::count_t               joint_rd,
    input  jhm_pkg::count_t               row_rd,
    input  jhm_pkg::count_t               col_rd,
    output jhm_pkg::joint_addr_t          joint_raddr,
    output logic                          joint_we,
    output jhm_pkg::joint_addr_t          joint_waddr,
    output jhm_pkg::count_t               joint_wdata,
    output jhm_pkg::a_idx_t               row_raddr,
    output logic                          row_we,
    output jhm_pkg::a_idx_t               row_waddr,
    output jhm_pkg::count_t               row_wdata,
    output jhm_pkg::b_idx_t               col_raddr,
    output logic                          col_we,
    output jhm_pkg::b_idx_t               col_waddr,
    output jhm_pkg::count_t               col_wdata,
    output logic                          done,
    output jhm_pkg::result_t              result
);

    jhm_pkg::a_idx_t      a_idx;
    jhm_pkg::b_idx_t      b_idx;
    logic                 bad;

    logic                 s1_valid_reg, s1_valid_next;
    logic [1:0]           s1_kind_reg;
    logic                 s1_bad_reg;
    jhm_pkg::a_idx_t      s1_a_reg;
    jhm_pkg::b_idx_t      s1_b_reg;
    jhm_pkg::joint_addr_t s1_j_reg;

    logic                 fj_valid_reg, fj_valid_next;
    jhm_pkg::joint_addr_t fj_addr_reg, fj_addr_next;
    jhm_pkg::count_t      fj_data_reg, fj_data_next;
    logic                 fr_valid_reg, fr_valid_next;
    jhm_pkg::a_idx_t      fr_addr_reg, fr_addr_next;
    jhm_pkg::count_t      fr_data_reg, fr_data_next;
    logic                 fc_valid_reg, fc_valid_next;
    jhm_pkg::b_idx_t      fc_addr_reg, fc_addr_next;
    jhm_pkg::count_t      fc_data_reg, fc_data_next;

    jhm_pkg::count_t      j_cur, r_cur, c_cur;
    jhm_pkg::count_t      j_new, r_new, c_new;
    logic                 do_acc, do_rd, flag_bad;

    logic                 done_reg, done_next;
    jhm_pkg::result_t     result_reg, result_next;

    assign a_idx       = jhm_pkg::A_IDX_W'(cmd.code_a);
    assign b_idx       = jhm_pkg::B_IDX_W'(cmd.code_b);
    assign bad         = !jhm_pkg::code_ok(cmd.code_a, bins_a_used, jhm_pkg::MAX_BINS_A) ||
                         !jhm_pkg::code_ok(cmd.code_b, bins_b_used, jhm_pkg::MAX_BINS_B);
    assign joint_raddr = jhm_pkg::joint_addr(a_idx, b_idx);
    assign row_raddr   = a_idx;
    assign col_raddr   = b_idx;

    assign s1_valid_next = accept && (cmd.kind != jhm_pkg::KIND_CLEAR);

    always_comb
    begin
        j_cur = (fj_valid_reg && fj_addr_reg == s1_j_reg) ? fj_data_reg : joint_rd;
        r_cur = (fr_valid_reg && fr_addr_reg == s1_a_reg) ? fr_data_reg : row_rd;
        c_cur = (fc_valid_reg && fc_addr_reg == s1_b_reg) ? fc_data_reg : col_rd;
        j_new = jhm_pkg::sat_inc(j_cur);
        r_new = jhm_pkg::sat_inc(r_cur);
        c_new = jhm_pkg::sat_inc(c_cur);

        do_acc   = s1_valid_reg && (s1_kind_reg == jhm_pkg::KIND_ACC) && !s1_bad_reg;
        do_rd    = s1_valid_reg && (s1_kind_reg == jhm_pkg::KIND_READ) && !s1_bad_reg;
        flag_bad = s1_valid_reg && s1_bad_reg &&
                   ((s1_kind_reg == jhm_pkg::KIND_ACC) || (s1_kind_reg == jhm_pkg::KIND_READ));

        if (ctrl.sweep)
        begin
            joint_we    = 1'b1;
            joint_waddr = ctrl.sweep_addr;
            joint_wdata = '0;
            row_we      = 1'b1;
            row_waddr   = jhm_pkg::A_IDX_W'(ctrl.sweep_addr);
            row_wdata   = '0;
            col_we      = 1'b1;
            col_waddr   = jhm_pkg::B_IDX_W'(ctrl.sweep_addr);
            col_wdata   = '0;
        end
        else
        begin
            joint_we    = do_acc;
            joint_waddr = s1_j_reg;
            joint_wdata = j_new;
            row_we      = do_acc;
            row_waddr   = s1_a_reg;
            row_wdata   = r_new;
            col_we      = do_acc;
            col_waddr   = s1_b_reg;
            col_wdata   = c_new;
        end

        fj_valid_next = fj_valid_reg || joint_we;
        fj_addr_next  = joint_we ? joint_waddr : fj_addr_reg;
        fj_data_next  = joint_we ? joint_wdata : fj_data_reg;
        fr_valid_next = fr_valid_reg || row_we;
        fr_addr_next  = row_we ? row_waddr : fr_addr_reg;
        fr_data_next  = row_we ? row_wdata : fr_data_reg;
        fc_valid_next = fc_valid_reg || col_we;
        fc_addr_next  = col_we ? col_waddr : fc_addr_reg;
        fc_data_next  = col_we ? col_wdata : fc_data_reg;

        result_next = '0;
        if (do_acc)
        begin
            result_next.joint_count = jhm_pkg::out32(j_new);
            result_next.row_count   = jhm_pkg::out32(r_new);
            result_next.col_count   = jhm_pkg::out32(c_new);
        end
        else if (do_rd)
        begin
            result_next.joint_count = jhm_pkg::out32(j_cur);
            result_next.row_count   = jhm_pkg::out32(r_cur);
            result_next.col_count   = jhm_pkg::out32(c_cur);
        end
        result_next.code_out_of_range = flag_bad;

        done_next = s1_valid_reg || ctrl.clr_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fj_valid_reg <= 1'b0;
            fr_valid_reg <= 1'b0;
            fc_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            fj_valid_reg <= fj_valid_next;
            fr_valid_reg <= fr_valid_next;
            fc_valid_reg <= fc_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= cmd.kind;
            s1_bad_reg  <= bad;
            s1_a_reg    <= a_idx;
            s1_b_reg    <= b_idx;
            s1_j_reg    <= joint_raddr;
        end
        fj_addr_reg <= fj_addr_next;
        fj_data_reg <= fj_data_next;
        fr_addr_reg <= fr_addr_next;
        fr_data_reg <= fr_data_next;
        fc_addr_reg <= fc_addr_next;
        fc_data_reg <= fc_data_next;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/core/joint_histogram_with_marginals_top.sv
// ============================================================================
// joint_histogram_with_marginals_top: joint 2-D histogram with marginals
// Accumulate and read beats: one per cycle while not busy; result registered after s1.
// Throughput is set by the single read-modify-write pass through the bin memory.
// Clear beat: busy over a JOINT_DEPTH (65536)-bin sweep, result strobed at the end.
// Reset: a 65536-bin clearing pass runs with busy high and no result.
// The receiver cannot stall; done marks each result for one cycle.
// ============================================================================
module joint_histogram_with_marginals_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  jhm_pkg::item_t                cmd,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [jhm_pkg::CFG_W-1:0]     cfg_data,
    output logic                          done,
    output jhm_pkg::result_t              result
);

    logic                          accept;
    jhm_pkg::ctrl_t                ctrl;
    logic [jhm_pkg::CFG_W-1:0]     bins_a_reg, bins_a_next;
    logic [jhm_pkg::CFG_W-1:0]     bins_b_reg, bins_b_next;

    jhm_pkg::joint_addr_t joint_raddr, joint_waddr;
    jhm_pkg::a_idx_t      row_raddr, row_waddr;
    jhm_pkg::b_idx_t      col_raddr, col_waddr;
    logic                 joint_we, row_we, col_we;
    jhm_pkg::count_t      joint_wdata, row_wdata, col_wdata;
    jhm_pkg::count_t      joint_rd, row_rd, col_rd;

    assign accept = start && !busy;

    always_comb
    begin
        bins_a_next = bins_a_reg;
        bins_b_next = bins_b_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                jhm_pkg::CFG_BINS_A: bins_a_next = cfg_data;
                jhm_pkg::CFG_BINS_B: bins_b_next = cfg_data;
                default:             bins_a_next = bins_a_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_a_reg <= jhm_pkg::BINS_USED_RESET;
            bins_b_reg <= jhm_pkg::BINS_USED_RESET;
        end
        else
        begin
            bins_a_reg <= bins_a_next;
            bins_b_reg <= bins_b_next;
        end
    end

    jhm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr_start (accept && (cmd.kind == jhm_pkg::KIND_CLEAR)),
        .busy      (busy),
        .ctrl      (ctrl)
    );

    jhm_upd u_upd (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cmd         (cmd),
        .bins_a_used (bins_a_reg),
        .bins_b_used (bins_b_reg),
        .ctrl        (ctrl),
        .joint_rd    (joint_rd),
        .row_rd      (row_rd),
        .col_rd      (col_rd),
        .joint_raddr (joint_raddr),
        .joint_we    (joint_we),
        .joint_waddr (joint_waddr),
        .joint_wdata (joint_wdata),
        .row_raddr   (row_raddr),
        .row_we      (row_we),
        .row_waddr   (row_waddr),
        .row_wdata   (row_wdata),
        .col_raddr   (col_raddr),
        .col_we      (col_we),
        .col_waddr   (col_waddr),
        .col_wdata   (col_wdata),
        .done        (done),
        .result      (result)
    );

    jhm_ram #(
        .DEPTH  (jhm_pkg::JOINT_DEPTH),
        .WIDTH  (jhm_pkg::COUNT_BITS),
        .ADDR_W (jhm_pkg::JOINT_ADDR_W)
    ) u_joint_ram (
        .clk   (clk),
        .we    (joint_we),
        .waddr (joint_waddr),
        .wdata (joint_wdata),
        .raddr (joint_raddr),
        .rdata (joint_rd)
    );

    jhm_ram #(
        .DEPTH  (jhm_pkg::MAX_BINS_A),
        .WIDTH  (jhm_pkg::COUNT_BITS),
        .ADDR_W (jhm_pkg::A_IDX_W)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rd)
    );

    jhm_ram #(
        .DEPTH  (jhm_pkg::MAX_BINS_B),
        .WIDTH  (jhm_pkg::COUNT_BITS),
        .ADDR_W (jhm_pkg::B_IDX_W)
    ) u_col_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .raddr (col_raddr),
        .rdata (col_rd)
    );

    a_clear_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.kind == jhm_pkg::KIND_CLEAR) |=> busy)
        else $error("clear beat did not start the clearing pass");

    a_bad_zero_counts: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.code_out_of_range |->
            (result.joint_count == 32'd0) && (result.row_count == 32'd0) &&
            (result.col_count == 32'd0))
        else $error("out-of-range beat returned nonzero counts");

    a_marginals_cover_bin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.row_count >= result.joint_count) &&
                 (result.col_count >= result.joint_count))
        else $error("marginal count below its bin count");

    a_no_update_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.sweep |-> (joint_wdata == '0) && (row_wdata == '0) && (col_wdata == '0))
        else $error("nonzero write during clearing pass");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: joint histogram with marginals, self-checking testbench
// Drives accumulate, read, clear and spare command beats under several bin
// limits and sender idle rates. Each accepted beat is run through a local
// histogram predictor, and every strobed result is checked against the
// oldest predicted result.
// ============================================================================
module tb;

    import jhm_pkg::*;

    localparam logic [1:0] KIND_SPARE     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 4 * JOINT_DEPTH;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             start    = 1'b0;
    logic             busy;
    item_t            cmd      = '0;
    logic             cfg_we   = 1'b0;
    logic             cfg_addr = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             done;
    result_t          result;

    joint_histogram_with_marginals_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result)
    );

    always #4 clk = ~clk;

    item_t       pending_cmds[$];
    result_t     expected_results[$];
    result_t     oldest_result;
    int unsigned cmds_queued   = 0;
    int unsigned cmds_accepted = 0;
    int          send_idle_pct = 0;
    int          idle_cycles   = 0;
    int          error_count   = 0;
    bit          cmd_taken     = 1'b0;

    count_t           bin_counts [JOINT_DEPTH];
    count_t           row_totals [MAX_BINS_A];
    count_t           col_totals [MAX_BINS_B];
    logic [CFG_W-1:0] rows_used = BINS_USED_RESET;
    logic [CFG_W-1:0] cols_used = BINS_USED_RESET;

    function automatic int code_limit(input logic [CFG_W-1:0] used, input int max_bins);
        return (int'(used) < max_bins) ? int'(used) : max_bins;
    endfunction

    function automatic count_t bump(input count_t v);
        return (v == {COUNT_BITS{1'b1}}) ? v : v + count_t'(1);
    endfunction

    function automatic logic [31:0] clamp32(input count_t v);
        return (64'(v) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
    endfunction

    function automatic void clear_counts();
        foreach (bin_counts[i]) bin_counts[i] = '0;
        foreach (row_totals[i]) row_totals[i] = '0;
        foreach (col_totals[i]) col_totals[i] = '0;
    endfunction

    function automatic result_t histogram_step(input item_t it);
        result_t r;
        int      idx;
        r = '0;
        case (it.kind)
            KIND_CLEAR: clear_counts();
            KIND_ACC, KIND_READ:
            begin
                if (int'(it.code_a) >= code_limit(rows_used, MAX_BINS_A) ||
                    int'(it.code_b) >= code_limit(cols_used, MAX_BINS_B))
                begin
                    r.code_out_of_range = 1'b1;
                end
                else
                begin
                    idx = int'(it.code_a) * MAX_BINS_B + int'(it.code_b);
                    if (it.kind == KIND_ACC)
                    begin
                        bin_counts[idx]        = bump(bin_counts[idx]);
                        row_totals[it.code_a]  = bump(row_totals[it.code_a]);
                        col_totals[it.code_b]  = bump(col_totals[it.code_b]);
                    end
                    r.joint_count = clamp32(bin_counts[idx]);
                    r.row_count   = clamp32(row_totals[it.code_a]);
                    r.col_count   = clamp32(col_totals[it.code_b]);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // sample at the rising edge: predict accepted beats, check strobed results
    always @(posedge clk)
    begin
        cmd_taken = rst_n && start && !busy;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_addr == CFG_BINS_A)
                    rows_used = cfg_data;
                else
                    cols_used = cfg_data;
            end
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_error($sformatf("result with no beat pending: %p", result));
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (result.joint_count !== oldest_result.joint_count)
                        report_error($sformatf("joint_count %0d, want %0d",
                                     result.joint_count, oldest_result.joint_count));
                    if (result.row_count !== oldest_result.row_count)
                        report_error($sformatf("row_count %0d, want %0d",
                                     result.row_count, oldest_result.row_count));
                    if (result.col_count !== oldest_result.col_count)
                        report_error($sformatf("col_count %0d, want %0d",
                                     result.col_count, oldest_result.col_count));
                    if (result.code_out_of_range !== oldest_result.code_out_of_range)
                        report_error($sformatf("code_out_of_range %b, want %b",
                                     result.code_out_of_range,
                                     oldest_result.code_out_of_range));
                end
            end
            if (cmd_taken)
            begin
                expected_results.push_back(histogram_step(cmd));
                cmds_accepted++;
            end
            if (cmd_taken || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no beat moved in %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // drive at the falling edge: hold a beat until taken, then advance
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || cmd_taken)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                cmd   <= pending_cmds.pop_front();
                start <= 1'b1;
            end
            else
            begin
                cmd   <= 18'($urandom);
                start <= 1'b0;
            end
        end
    end

    function automatic item_t make_cmd(input logic [1:0] kind, input int a, input int b);
        item_t it;
        it.kind   = kind;
        it.code_a = 8'(a);
        it.code_b = 8'(b);
        return it;
    endfunction

    task automatic queue_cmd(input item_t it);
        pending_cmds.push_back(it);
        cmds_queued++;
    endtask

    // cluster codes at both ends of the valid range so bins build up
    function automatic logic [7:0] pick_code(input int lim);
        int unsigned r;
        int unsigned span;
        r    = $urandom_range(9, 0);
        span = (lim > 3) ? 2 : lim - 1;
        if (lim == 0 || r == 9)
            return 8'($urandom_range(255, 0));
        if (r < 4)
            return 8'(lim - 1 - $urandom_range(span, 0));
        if (r < 6)
            return 8'($urandom_range(span, 0));
        return 8'($urandom_range(lim - 1, 0));
    endfunction

    function automatic item_t random_cmd(input int lim_a, input int lim_b);
        int unsigned r;
        logic [1:0]  kind;
        r    = $urandom_range(99, 0);
        kind = (r < 55) ? KIND_ACC : (r < 90) ? KIND_READ : KIND_SPARE;
        return make_cmd(kind, int'(pick_code(lim_a)), int'(pick_code(lim_b)));
    endfunction

    task automatic settle();
        while (cmds_accepted != cmds_queued || expected_results.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic idx, input int value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= CFG_W'(value);
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input int used_a, input int used_b, input int idle_pct,
                             input int count, input bit with_clear);
        int lim_a;
        int lim_b;
        settle();
        write_limit(CFG_BINS_A, used_a);
        write_limit(CFG_BINS_B, used_b);
        send_idle_pct = idle_pct;
        lim_a = code_limit(CFG_W'(used_a), MAX_BINS_A);
        lim_b = code_limit(CFG_W'(used_b), MAX_BINS_B);
        for (int i = 0; i < count; i++)
        begin
            if (with_clear && i == count / 2)
                queue_cmd(make_cmd(KIND_CLEAR, $urandom_range(255, 0), $urandom_range(255, 0)));
            queue_cmd(random_cmd(lim_a, lim_b));
        end
    endtask

    initial
    begin
        clear_counts();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_cmd(make_cmd(KIND_READ,    0,   0));
        queue_cmd(make_cmd(KIND_ACC,     0,   0));
        queue_cmd(make_cmd(KIND_ACC,     0,   0));
        queue_cmd(make_cmd(KIND_ACC,   255, 255));
        queue_cmd(make_cmd(KIND_ACC,   255,   0));
        queue_cmd(make_cmd(KIND_ACC,     0, 255));
        queue_cmd(make_cmd(KIND_ACC,   170,  85));
        queue_cmd(make_cmd(KIND_ACC,    85, 170));
        queue_cmd(make_cmd(KIND_READ,    0,   0));
        queue_cmd(make_cmd(KIND_READ,  255, 255));
        queue_cmd(make_cmd(KIND_READ,  255,   0));
        queue_cmd(make_cmd(KIND_SPARE, 255, 255));
        queue_cmd(make_cmd(KIND_CLEAR,   0,   0));
        queue_cmd(make_cmd(KIND_READ,    0,   0));
        queue_cmd(make_cmd(KIND_READ,  255, 255));
        queue_cmd(make_cmd(KIND_ACC,   255, 255));

        settle();
        write_limit(CFG_BINS_A, 4);
        write_limit(CFG_BINS_B, 9);
        queue_cmd(make_cmd(KIND_ACC,     4,   0));
        queue_cmd(make_cmd(KIND_ACC,     0,   9));
        queue_cmd(make_cmd(KIND_READ,    3,   8));
        queue_cmd(make_cmd(KIND_ACC,     3,   8));
        queue_cmd(make_cmd(KIND_ACC,     3,   8));
        queue_cmd(make_cmd(KIND_READ,  255, 255));

        run_phase(256, 256,  0, 200, 1'b0);
        run_phase(1,     1, 86, 150, 1'b0);
        run_phase(0,   256, 14,  60, 1'b0);
        run_phase(511, 300, 86, 200, 1'b1);
        run_phase($urandom_range(255, 2), $urandom_range(255, 2), 14, 200, 1'b0);
        run_phase(256,   1,  0, 150, 1'b0);
        run_phase(37,  256, 86, 190, 1'b0);

        settle();
        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
